// File: src/ccd_pkg.sv
package ccd_pkg;

    typedef enum logic [2:0] {
        RES_STORED     = 3'd0,
        RES_FULL       = 3'd1,
        RES_EMPTY      = 3'd2,
        RES_INCOMPLETE = 3'd3,
        RES_UNKNOWN    = 3'd4,
        RES_CRC_BAD    = 3'd5,
        RES_ACCEPTED   = 3'd6
    } result_t;

    localparam logic       KIND_PUSH    = 1'b0;
    localparam logic       KIND_PARSE   = 1'b1;

    localparam logic [7:0] CMD_START    = 8'd1;
    localparam logic [7:0] CMD_PAGE     = 8'd2;
    localparam logic [7:0] CMD_READBACK = 8'd4;
    localparam logic [7:0] CMD_LAST     = 8'd5;
    localparam logic [7:0] ACK_BASE     = 8'h54;

    localparam logic [8:0] LEN_START    = 9'd7;
    localparam logic [8:0] LEN_PAGE     = 9'd259;
    localparam logic [8:0] LEN_SHORT    = 9'd3;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [8:0]  PAGE_SIZE   = 9'd256;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            if (crc[15] ^ data[i]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// File: src/ccd_ring.sv
module ccd_ring #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/crc_checked_command_deframer.sv
// Receive ring for command frames protected by a CRC16-CCITT. A push beat
// (tuser 0) stores one byte. A parse beat (tuser 1) reads the frame at the
// head of the ring one byte per cycle through the single read port of the
// ring memory; an empty ring, an unknown command or an incomplete head ends
// the parse without reading the rest of the frame. A result beat that waits
// on the output holds the block for as long as it waits. Exactly one result
// beat is returned per input beat, in order. A new input beat is taken as
// soon as the block is idle, even while the previous result still waits on
// the output. The ring holds at most RING_DEPTH-1 bytes and needs no
// clearing after reset.
module crc_checked_command_deframer #(
    parameter int RING_DEPTH = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte[7:0]
    input  logic         s_tuser,   // kind[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // command[7:0], ack_code[15:8], crc_echo[31:16], computed_crc[47:32],
    // image_size[79:48], page_address[103:80], page_bytes[112:104],
    // buffered_count[124:113], zero padding[127:125]
    output logic [127:0] m_tdata,
    output logic [2:0]   m_tuser    // status[2:0]
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int CMPW = 13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_WALK,
        ST_EVAL,
        ST_FIN
    } state_t;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [8:0] n);
        logic [AW:0] sum;
        sum = {1'b0, a} + (AW+1)'(n);
        if (sum >= (AW+1)'(RING_DEPTH)) begin
            sum = sum - (AW+1)'(RING_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t                   state_reg;
    logic [AW-1:0]            wr_idx_reg;
    logic [AW-1:0]            rd_idx_reg;
    logic [AW-1:0]            count_reg;
    logic [AW-1:0]            ptr_reg;
    logic [8:0]               off_reg;
    logic [8:0]               len_reg;
    logic [23:0]              page_idx_reg;
    logic [23:0]              page_total_reg;
    logic [7:0]               last_bytes_reg;
    logic [8:0]               cur_bytes_reg;

    ccd_pkg::result_t         res_status_reg;
    logic [7:0]               cmd_reg;
    logic [15:0]              crc_reg;
    logic [15:0]              echo_reg;
    logic                     checked_reg;
    logic [31:0]              fsize_reg;
    logic [31:0]              res_fsize_reg;
    logic [23:0]              res_paddr_reg;
    logic [8:0]               res_pbytes_reg;

    logic                     m_tvalid_reg;
    logic [127:0]             m_tdata_reg;
    logic [2:0]               m_tuser_reg;

    logic                     accept;
    logic                     full;
    logic                     mem_wr_en;
    logic [AW-1:0]            mem_rd_addr;
    logic [7:0]               mem_rd_data;
    logic                     out_free;
    logic                     crc_ok;
    logic [24:0]              page_calc;
    logic [7:0]               ack_code;
    logic [15:0]              echo_out;
    logic [15:0]              calc_out;
    logic [8:0]               page_next_bytes;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign full        = (count_reg == AW'(RING_DEPTH - 1));
    assign mem_wr_en   = accept && (s_tuser == ccd_pkg::KIND_PUSH) && !full;
    assign mem_rd_addr = (state_reg == ST_IDLE) ? rd_idx_reg : ring_inc(ptr_reg);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign crc_ok      = (crc_reg == echo_reg);
    assign page_calc   = {1'b0, fsize_reg[31:8]} + 25'(fsize_reg[7:0] != 8'd0);
    assign ack_code    = (res_status_reg == ccd_pkg::RES_ACCEPTED)
                         ? ccd_pkg::ACK_BASE + cmd_reg : 8'd0;
    assign echo_out    = checked_reg ? echo_reg : 16'd0;
    assign calc_out    = checked_reg ? crc_reg : 16'd0;
    assign page_next_bytes = ((page_total_reg != 24'd0)
                              && (page_idx_reg == page_total_reg - 24'd1)
                              && (last_bytes_reg != 8'd0))
                             ? {1'b0, last_bytes_reg} : cur_bytes_reg;

    ccd_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (s_tdata),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            count_reg      <= '0;
            page_idx_reg   <= '0;
            page_total_reg <= '0;
            last_bytes_reg <= '0;
            cur_bytes_reg  <= ccd_pkg::PAGE_SIZE;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tready && !(state_reg == ST_FIN && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg        <= '0;
                        checked_reg    <= 1'b0;
                        res_fsize_reg  <= '0;
                        res_paddr_reg  <= '0;
                        res_pbytes_reg <= '0;
                        ptr_reg        <= rd_idx_reg;
                        if (s_tuser == ccd_pkg::KIND_PUSH) begin
                            if (full) begin
                                res_status_reg <= ccd_pkg::RES_FULL;
                            end else begin
                                wr_idx_reg     <= ring_inc(wr_idx_reg);
                                count_reg      <= count_reg + 1'b1;
                                res_status_reg <= ccd_pkg::RES_STORED;
                            end
                            state_reg <= ST_FIN;
                        end else if (count_reg == '0) begin
                            res_status_reg <= ccd_pkg::RES_EMPTY;
                            state_reg      <= ST_FIN;
                        end else begin
                            state_reg <= ST_CMD;
                        end
                    end
                end
                ST_CMD: begin
                    cmd_reg <= mem_rd_data;
                    if (mem_rd_data == ccd_pkg::CMD_START) begin
                        page_idx_reg <= '0;
                    end
                    if (mem_rd_data == ccd_pkg::CMD_START) begin
                        len_reg <= ccd_pkg::LEN_START;
                    end else if (mem_rd_data == ccd_pkg::CMD_PAGE) begin
                        len_reg <= ccd_pkg::LEN_PAGE;
                    end else begin
                        len_reg <= ccd_pkg::LEN_SHORT;
                    end
                    crc_reg <= ccd_pkg::crc16_byte(ccd_pkg::CRC_INIT, mem_rd_data);
                    ptr_reg <= ring_inc(ptr_reg);
                    off_reg <= 9'd1;
                    if (mem_rd_data == 8'd0 || mem_rd_data > ccd_pkg::CMD_LAST) begin
                        rd_idx_reg     <= ring_inc(rd_idx_reg);
                        count_reg      <= count_reg - 1'b1;
                        res_status_reg <= ccd_pkg::RES_UNKNOWN;
                        state_reg      <= ST_FIN;
                    end else if (CMPW'(count_reg) < CMPW'(
                            (mem_rd_data == ccd_pkg::CMD_START) ? ccd_pkg::LEN_START :
                            (mem_rd_data == ccd_pkg::CMD_PAGE)  ? ccd_pkg::LEN_PAGE :
                                                                  ccd_pkg::LEN_SHORT)) begin
                        res_status_reg <= ccd_pkg::RES_INCOMPLETE;
                        state_reg      <= ST_FIN;
                    end else begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    ptr_reg <= ring_inc(ptr_reg);
                    off_reg <= off_reg + 1'b1;
                    if (off_reg < len_reg - 9'd2) begin
                        crc_reg <= ccd_pkg::crc16_byte(crc_reg, mem_rd_data);
                    end
                    unique case (off_reg)
                        9'd1:    fsize_reg[7:0]   <= mem_rd_data;
                        9'd2:    fsize_reg[15:8]  <= mem_rd_data;
                        9'd3:    fsize_reg[23:16] <= mem_rd_data;
                        9'd4:    fsize_reg[31:24] <= mem_rd_data;
                        default: ;
                    endcase
                    if (off_reg == len_reg - 9'd2) begin
                        echo_reg[7:0] <= mem_rd_data;
                    end
                    if (off_reg == len_reg - 9'd1) begin
                        echo_reg[15:8] <= mem_rd_data;
                        state_reg      <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    checked_reg <= 1'b1;
                    state_reg   <= ST_FIN;
                    if (!crc_ok) begin
                        rd_idx_reg     <= ring_inc(rd_idx_reg);
                        count_reg      <= count_reg - 1'b1;
                        res_status_reg <= ccd_pkg::RES_CRC_BAD;
                    end else begin
                        rd_idx_reg     <= ring_add(rd_idx_reg, len_reg);
                        count_reg      <= count_reg - AW'(len_reg);
                        res_status_reg <= ccd_pkg::RES_ACCEPTED;
                        if (cmd_reg == ccd_pkg::CMD_START) begin
                            res_fsize_reg  <= fsize_reg;
                            cur_bytes_reg  <= ccd_pkg::PAGE_SIZE;
                            last_bytes_reg <= fsize_reg[7:0];
                            page_total_reg <= page_calc[24] ? 24'hFFFFFF : page_calc[23:0];
                        end else if (cmd_reg == ccd_pkg::CMD_PAGE) begin
                            cur_bytes_reg  <= page_next_bytes;
                            res_pbytes_reg <= page_next_bytes;
                            res_paddr_reg  <= {page_idx_reg[15:0], 8'd0};
                            if (page_idx_reg < page_total_reg) begin
                                page_idx_reg <= page_idx_reg + 24'd1;
                            end
                        end else if (cmd_reg == ccd_pkg::CMD_READBACK) begin
                            page_idx_reg <= '0;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {3'd0, 12'(count_reg), res_pbytes_reg,
                                         res_paddr_reg, res_fsize_reg, calc_out,
                                         echo_out, ack_code, cmd_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
